>>> rtl/dpff_pkg.sv
// Package for the demand paging frame manager with FIFO replacement.
// Holds the sizes, operation codes, channel structs and the controller
// command type. It has no dependencies.
package dpff_pkg;

   // Frame pool size and the widths of the fields in the channel structs.
   localparam int FRAMES  = 4;
   localparam int FRAME_W = $clog2(FRAMES);
   localparam int COUNT_W = $clog2(FRAMES + 1);
   localparam int TASK_W  = 2;
   localparam int PAGE_W  = 8;

   // Operation codes of the request channel.
   localparam logic OP_ACCESS  = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [TASK_W-1:0] task_id;
      logic [PAGE_W-1:0] page_number;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [FRAME_W-1:0] frame_index;
      logic               evicted;
      logic [TASK_W-1:0]  evicted_task;
      logic [PAGE_W-1:0]  evicted_page;
      logic [COUNT_W-1:0] freed_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

>>> rtl/demand_paging_fifo_frames.sv
// Top level of the demand paging frame manager with FIFO replacement.
// Instantiates dpff_ctrl and dpff_datapath; depends on dpff_pkg.
//
// Usage: the request channel (req_valid, req_stall, req_payload) carries
// one item per transfer. An access item names a task and a page; a hit
// returns the frame that holds the pair. A miss takes the lowest free
// frame or, when all four frames are busy, evicts the frame loaded
// longest ago and reports its owner and page. A release item frees every
// frame of a task, drops those frames from the load order and reports how
// many were freed. Every request yields exactly one result transfer on
// the response channel (rsp_valid, rsp_stall, rsp_payload).
// Timing: a request is captured into the request register at its transfer
// and executed in the execute step, which loads the output register once it
// is free; the result is offered from that register. A new request is taken
// only after the previous one is executed, set by the controller's steps.
// The response sits in an output register; while the receiver stalls it
// holds steady, the block still takes one more request and then waits in
// the execute step until the register frees up.
// Reset (synchronous, active high) empties all frames and the load order
// and drops any pending result.
module demand_paging_fifo_frames (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dpff_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dpff_pkg::rsp_type rsp_payload
);

   // Command bundle from the controller to the datapath.
   dpff_pkg::cmd_type cmd;

   // The controller sequences each request through capture and execute
   // and owns the response valid flag.
   dpff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath keeps the frame tables and forms the result.
   dpff_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/dpff_ctrl.sv
// Controller of the frame manager: a two state machine and the result
// valid flag. It issues capture and execute commands to the datapath.
// Depends on dpff_pkg.
module dpff_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dpff_pkg::cmd_type cmd
);

   dpff_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   // The output register can take a new result when it is empty or when
   // its present result is transferred at this edge.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != dpff_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      case (state_ff)
         dpff_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = dpff_pkg::ST_EXEC;
            end
         end
         dpff_pkg::ST_EXEC: begin
            if (out_free) begin
               cmd.execute = 1'b1;
               state_in    = dpff_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dpff_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dpff_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // A capture always moves the controller to the execute state next.
   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == dpff_pkg::ST_EXEC))
      else $error("capture not followed by execute state");

   // A new result only appears after an execute step.
   a_valid_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.execute))
      else $error("result valid without execute");

   // The datapath never captures and executes in the same cycle.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.execute))
      else $error("capture and execute together");
`endif

endmodule

>>> rtl/dpff_datapath.sv
// Datapath of the frame manager: request register, frame tables with a
// load rank per frame for FIFO order, lookup logic and result register.
// Depends on dpff_pkg.
module dpff_datapath (
   input  logic              clock,
   input  logic              reset,
   input  dpff_pkg::cmd_type cmd,
   input  dpff_pkg::req_type req_payload,
   output dpff_pkg::rsp_type rsp_payload
);

   localparam int FRAMES  = dpff_pkg::FRAMES;
   localparam int FRAME_W = dpff_pkg::FRAME_W;
   localparam int COUNT_W = dpff_pkg::COUNT_W;
   localparam int TASK_W  = dpff_pkg::TASK_W;
   localparam int PAGE_W  = dpff_pkg::PAGE_W;

   dpff_pkg::req_type  req_ff;
   dpff_pkg::rsp_type  rsp_ff, rsp_in;

   logic [FRAMES-1:0]  busy_ff, busy_in;
   logic [TASK_W-1:0]  owner_ff [FRAMES];
   logic [TASK_W-1:0]  owner_in [FRAMES];
   logic [PAGE_W-1:0]  page_ff  [FRAMES];
   logic [PAGE_W-1:0]  page_in  [FRAMES];
   // Position of each busy frame in load order; zero is the oldest.
   logic [FRAME_W-1:0] rank_ff  [FRAMES];
   logic [FRAME_W-1:0] rank_in  [FRAMES];

   logic [FRAMES-1:0]  match;
   logic [FRAMES-1:0]  rel;
   logic [FRAMES-1:0]  oldest;
   logic               hit_found, free_found, victim_found;
   logic [FRAME_W-1:0] hit_idx, free_idx, victim_idx;
   logic [COUNT_W-1:0] busy_cnt, freed_cnt;
   logic [COUNT_W-1:0] dec [FRAMES];

   assign rsp_payload = rsp_ff;

   // Per frame compare and lowest index searches over the four frames.
   always_comb begin
      hit_found    = 1'b0;
      free_found   = 1'b0;
      victim_found = 1'b0;
      hit_idx      = '0;
      free_idx     = '0;
      victim_idx   = '0;
      busy_cnt     = '0;
      freed_cnt    = '0;
      for (int i = 0; i < FRAMES; i++) begin
         match[i]  = busy_ff[i] && (owner_ff[i] == req_ff.task_id)
                     && (page_ff[i] == req_ff.page_number);
         rel[i]    = busy_ff[i] && (owner_ff[i] == req_ff.task_id);
         oldest[i] = busy_ff[i] && (rank_ff[i] == '0);
         busy_cnt  = busy_cnt + COUNT_W'(busy_ff[i]);
         freed_cnt = freed_cnt + COUNT_W'(rel[i]);
      end
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_found = 1'b1;
            hit_idx   = FRAME_W'(i);
         end
         if (!busy_ff[i]) begin
            free_found = 1'b1;
            free_idx   = FRAME_W'(i);
         end
         if (oldest[i]) begin
            victim_found = 1'b1;
            victim_idx   = FRAME_W'(i);
         end
      end
      // Number of released frames loaded before each frame.
      for (int i = 0; i < FRAMES; i++) begin
         dec[i] = '0;
         for (int j = 0; j < FRAMES; j++) begin
            dec[i] = dec[i] + COUNT_W'(rel[j] && (rank_ff[j] < rank_ff[i]));
         end
      end
   end

   // Table update and result for the captured request.
   always_comb begin
      busy_in = busy_ff;
      for (int i = 0; i < FRAMES; i++) begin
         owner_in[i] = owner_ff[i];
         page_in[i]  = page_ff[i];
         rank_in[i]  = rank_ff[i];
      end
      rsp_in = '0;
      if (req_ff.operation == dpff_pkg::OP_RELEASE) begin
         rsp_in.freed_count = freed_cnt;
         for (int i = 0; i < FRAMES; i++) begin
            if (rel[i]) begin
               busy_in[i]  = 1'b0;
               owner_in[i] = '0;
               page_in[i]  = '0;
            end else begin
               rank_in[i] = rank_ff[i] - dec[i][FRAME_W-1:0];
            end
         end
      end else if (hit_found) begin
         rsp_in.hit         = 1'b1;
         rsp_in.frame_index = hit_idx;
      end else if (free_found) begin
         rsp_in.frame_index  = free_idx;
         busy_in[free_idx]   = 1'b1;
         owner_in[free_idx]  = req_ff.task_id;
         page_in[free_idx]   = req_ff.page_number;
         rank_in[free_idx]   = busy_cnt[FRAME_W-1:0];
      end else if (victim_found) begin
         rsp_in.frame_index  = victim_idx;
         rsp_in.evicted      = 1'b1;
         rsp_in.evicted_task = owner_ff[victim_idx];
         rsp_in.evicted_page = page_ff[victim_idx];
         for (int i = 0; i < FRAMES; i++) begin
            rank_in[i] = rank_ff[i] - FRAME_W'(1);
         end
         owner_in[victim_idx] = req_ff.task_id;
         page_in[victim_idx]  = req_ff.page_number;
         rank_in[victim_idx]  = FRAME_W'(FRAMES - 1);
      end else begin
         // Full pool without an oldest frame: reuse frame zero silently.
         busy_in[0]  = 1'b1;
         owner_in[0] = req_ff.task_id;
         page_in[0]  = req_ff.page_number;
         rank_in[0]  = FRAME_W'(FRAMES - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            owner_ff[i] <= '0;
            page_ff[i]  <= '0;
            rank_ff[i]  <= '0;
         end
      end else if (cmd.execute) begin
         busy_ff <= busy_in;
         for (int i = 0; i < FRAMES; i++) begin
            owner_ff[i] <= owner_in[i];
            page_ff[i]  <= page_in[i];
            rank_ff[i]  <= rank_in[i];
         end
      end
   end

`ifndef SYNTHESIS
   // With every frame busy there is always exactly one oldest frame.
   a_full_has_oldest: assert property (@(posedge clock) disable iff (reset)
      (&busy_ff) |-> $onehot(oldest))
      else $error("full pool without a unique oldest frame");

   // A hit never reports an eviction or freed frames.
   a_hit_clean: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.execute) && rsp_ff.hit |-> !rsp_ff.evicted && (rsp_ff.freed_count == '0))
      else $error("hit with eviction or release data");

   // An eviction only happens when the pool was full.
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && rsp_in.evicted |-> (&busy_ff))
      else $error("eviction with a free frame");
`endif

endmodule
